### rtl/lsrc_pkg.sv
// shared types, constants and helper functions for the segment clipper
package lsrc_pkg;

    localparam int CW = 32;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int NEDGE = 4;
    localparam int NSTAGE = DW + 3;

    typedef enum logic [1:0]
    {
        CFG_LEFT   = 2'd0,
        CFG_BOTTOM = 2'd1,
        CFG_RIGHT  = 2'd2,
        CFG_TOP    = 2'd3
    } cfg_idx_t;

    localparam int E_BOT   = 0;
    localparam int E_TOP   = 1;
    localparam int E_LEFT  = 2;
    localparam int E_RIGHT = 3;

    typedef struct packed
    {
        logic signed [CW-1:0] a0;
        logic [DW-1:0]        uc;
        logic                 neg;
        logic                 span;
        logic                 par;
        logic                 parhit;
    } edge_ctl_t;

    typedef struct packed
    {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic                 reject;
        logic                 in0;
        logic                 in1;
        edge_ctl_t [NEDGE-1:0] e;
    } seg_t;

    typedef struct packed
    {
        edge_ctl_t     ctl;
        logic [DW-1:0] ua;
        logic [DW-1:0] ub;
    } edge_prep_t;

    typedef struct packed
    {
        logic                 hit;
        logic signed [CW-1:0] ca;
    } edge_hit_t;

    typedef logic [NEDGE-1:0][PW-1:0] div_w_t;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] d);
        logic [DW-1:0] r;
        r = d[DW-1] ? DW'(-d) : DW'(d);
        return r;
    endfunction

    function automatic edge_prep_t edge_prep(
        input logic signed [CW-1:0] a0,
        input logic signed [CW-1:0] a1,
        input logic signed [CW-1:0] b0,
        input logic signed [CW-1:0] b1,
        input logic signed [CW-1:0] edge_v
    );
        edge_prep_t r;
        logic signed [DW-1:0] da;
        logic signed [DW-1:0] db;
        logic signed [DW-1:0] dc;
        logic signed [CW-1:0] bmin;
        logic signed [CW-1:0] bmax;
        da = {a1[CW-1], a1} - {a0[CW-1], a0};
        db = {edge_v[CW-1], edge_v} - {b0[CW-1], b0};
        dc = {b1[CW-1], b1} - {b0[CW-1], b0};
        bmin = (b0 < b1) ? b0 : b1;
        bmax = (b0 < b1) ? b1 : b0;
        r.ctl.a0 = a0;
        r.ctl.uc = mag(dc);
        r.ctl.neg = da[DW-1] ^ db[DW-1] ^ dc[DW-1];
        r.ctl.span = (edge_v >= bmin) && (edge_v <= bmax);
        r.ctl.par = (b0 == b1);
        r.ctl.parhit = (b1 == edge_v);
        r.ua = mag(da);
        r.ub = mag(db);
        return r;
    endfunction

    function automatic edge_hit_t edge_hit(
        input edge_ctl_t ctl,
        input logic [DW-1:0] q,
        input logic signed [CW-1:0] lo,
        input logic signed [CW-1:0] hi
    );
        edge_hit_t r;
        logic signed [DW:0] qs;
        logic signed [DW:0] ca;
        logic signed [DW:0] los;
        logic signed [DW:0] his;
        qs = ctl.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        ca = $signed({{2{ctl.a0[CW-1]}}, ctl.a0}) + qs;
        los = $signed({{2{lo[CW-1]}}, lo});
        his = $signed({{2{hi[CW-1]}}, hi});
        if (ctl.par)
        begin
            r.hit = ctl.parhit;
            r.ca = ctl.a0;
        end
        else
        begin
            r.hit = ctl.span && (ca >= los) && (ca <= his);
            r.ca = ca[CW-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/lsrc_if.sv
// stream interfaces for segments in and clipped results out
interface lsrc_seg_if;
    import lsrc_pkg::*;
    logic valid;
    logic ready;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsrc_res_if;
    import lsrc_pkg::*;
    logic valid;
    logic ready;
    logic visible;
    logic signed [CW-1:0] out_start_x;
    logic signed [CW-1:0] out_start_y;
    logic signed [CW-1:0] out_end_x;
    logic signed [CW-1:0] out_end_y;
    modport source (output valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
                    input ready);
    modport sink (input valid, visible, out_start_x, out_start_y, out_end_x, out_end_y,
                  output ready);
endinterface

### rtl/line_segment_rect_clipper_top.sv
// top level of the line segment rectangle clipper
//
// segments arrive on seg_in, one transfer per segment; each yields exactly
// one transfer on res_out with visible and the clipped end points.
// the clip rectangle is written through cfg_we / cfg_index / cfg_wdata
// (left, bottom, right, top) while no segment is in flight.
// the pipeline from input transfer to output transfer holds one setup stage,
// one multiply stage, one stage per quotient bit of the four parallel
// crossing dividers and one output stage.
// throughput is one segment per cycle while the receiver does not stall; the
// restoring divider chain sets the depth, each stage resolving one quotient bit.
// every stage holds its own valid bit and advances when its successor can
// take it, so bubbles close up while the receiver stalls and input keeps
// flowing until every stage is full.
// reset clears all valid bits and sets the rectangle to zero.
module line_segment_rect_clipper_top
    import lsrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [CW-1:0] cfg_wdata,
    lsrc_seg_if.sink      seg_in,
    lsrc_res_if.source    res_out
);

    logic signed [CW-1:0] clip_left_reg, clip_bottom_reg, clip_right_reg, clip_top_reg;
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] v;
    seg_t   seg_s [NSTAGE-1];
    div_w_t w_s [NSTAGE-1];
    logic [NEDGE-1:0][DW-1:0] ua, ub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg <= '0;
            clip_bottom_reg <= '0;
            clip_right_reg <= '0;
            clip_top_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LEFT:   clip_left_reg <= cfg_wdata;
                CFG_BOTTOM: clip_bottom_reg <= cfg_wdata;
                CFG_RIGHT:  clip_right_reg <= cfg_wdata;
                CFG_TOP:    clip_top_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb
    begin
        en[NSTAGE-1] = !v[NSTAGE-1] || res_out.ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            en[i] = !v[i] || en[i+1];
        end
    end

    assign seg_in.ready = en[0];
    assign res_out.valid = v[NSTAGE-1];

    lsrc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en[0]),
        .in_valid    (seg_in.valid),
        .x0          (seg_in.start_x),
        .y0          (seg_in.start_y),
        .x1          (seg_in.end_x),
        .y1          (seg_in.end_y),
        .clip_left   (clip_left_reg),
        .clip_bottom (clip_bottom_reg),
        .clip_right  (clip_right_reg),
        .clip_top    (clip_top_reg),
        .valid_reg   (v[0]),
        .seg_reg     (seg_s[0]),
        .ua_reg      (ua),
        .ub_reg      (ub)
    );

    // w_s[0] is unused by the front stage; tie it off
    assign w_s[0] = '0;

    lsrc_mul u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en[1]),
        .in_valid  (v[0]),
        .seg_in    (seg_s[0]),
        .ua        (ua),
        .ub        (ub),
        .valid_reg (v[1]),
        .seg_reg   (seg_s[1]),
        .w_reg     (w_s[1])
    );

    for (genvar i = 0; i < DW; i++)
    begin : g_div
        lsrc_div_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en[i+2]),
            .in_valid  (v[i+1]),
            .seg_in    (seg_s[i+1]),
            .w_in      (w_s[i+1]),
            .valid_reg (v[i+2]),
            .seg_reg   (seg_s[i+2]),
            .w_reg     (w_s[i+2])
        );
    end

    lsrc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en[NSTAGE-1]),
        .in_valid    (v[NSTAGE-2]),
        .seg_in      (seg_s[NSTAGE-2]),
        .w_in        (w_s[NSTAGE-2] | w_s[0]),
        .clip_left   (clip_left_reg),
        .clip_bottom (clip_bottom_reg),
        .clip_right  (clip_right_reg),
        .clip_top    (clip_top_reg),
        .valid_reg   (v[NSTAGE-1]),
        .vis_reg     (res_out.visible),
        .sx_reg      (res_out.out_start_x),
        .sy_reg      (res_out.out_start_y),
        .ex_reg      (res_out.out_end_x),
        .ey_reg      (res_out.out_end_y)
    );

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        seg_in.valid && seg_in.ready |=> v[0])
        else $error("accepted segment did not enter the first stage");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.visible |->
            res_out.out_start_x == '0 && res_out.out_start_y == '0 &&
            res_out.out_end_x == '0 && res_out.out_end_y == '0)
        else $error("hidden result carries nonzero coordinates");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !v[NSTAGE-1] |-> seg_in.ready)
        else $error("input stalled with empty output stage");

endmodule

### rtl/lsrc_front.sv
// first stage: outcodes, differences and magnitudes per edge
module lsrc_front
    import lsrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] x0,
    input  logic signed [CW-1:0] y0,
    input  logic signed [CW-1:0] x1,
    input  logic signed [CW-1:0] y1,
    input  logic signed [CW-1:0] clip_left,
    input  logic signed [CW-1:0] clip_bottom,
    input  logic signed [CW-1:0] clip_right,
    input  logic signed [CW-1:0] clip_top,
    output logic                 valid_reg,
    output seg_t                 seg_reg,
    output logic [NEDGE-1:0][DW-1:0] ua_reg,
    output logic [NEDGE-1:0][DW-1:0] ub_reg
);

    seg_t seg_next;
    edge_prep_t [NEDGE-1:0] prep;

    always_comb
    begin
        prep[E_BOT]   = edge_prep(x0, x1, y0, y1, clip_bottom);
        prep[E_TOP]   = edge_prep(x0, x1, y0, y1, clip_top);
        prep[E_LEFT]  = edge_prep(y0, y1, x0, x1, clip_left);
        prep[E_RIGHT] = edge_prep(y0, y1, x0, x1, clip_right);
        seg_next.x0 = x0;
        seg_next.y0 = y0;
        seg_next.x1 = x1;
        seg_next.y1 = y1;
        seg_next.reject = (x0 < clip_left && x1 < clip_left) ||
                          (y0 < clip_bottom && y1 < clip_bottom) ||
                          (x0 > clip_right && x1 > clip_right) ||
                          (y0 > clip_top && y1 > clip_top);
        seg_next.in0 = x0 >= clip_left && x0 <= clip_right &&
                       y0 >= clip_bottom && y0 <= clip_top;
        seg_next.in1 = x1 >= clip_left && x1 <= clip_right &&
                       y1 >= clip_bottom && y1 <= clip_top;
        for (int k = 0; k < NEDGE; k++)
        begin
            seg_next.e[k] = prep[k].ctl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg <= seg_next;
            for (int k = 0; k < NEDGE; k++)
            begin
                ua_reg[k] <= prep[k].ua;
                ub_reg[k] <= prep[k].ub;
            end
        end
    end

endmodule

### rtl/lsrc_mul.sv
// product stage: magnitude of along-axis delta times edge offset
module lsrc_mul
    import lsrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  seg_t seg_in,
    input  logic [NEDGE-1:0][DW-1:0] ua,
    input  logic [NEDGE-1:0][DW-1:0] ub,
    output logic valid_reg,
    output seg_t seg_reg,
    output div_w_t w_reg
);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg <= seg_in;
            for (int k = 0; k < NEDGE; k++)
            begin
                w_reg[k] <= PW'(ua[k]) * PW'(ub[k]);
            end
        end
    end

endmodule

### rtl/lsrc_div_step.sv
// one restoring division step: one quotient bit per edge
module lsrc_div_step
    import lsrc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  seg_t   seg_in,
    input  div_w_t w_in,
    output logic   valid_reg,
    output seg_t   seg_reg,
    output div_w_t w_reg
);

    div_w_t w_next;

    always_comb
    begin
        for (int k = 0; k < NEDGE; k++)
        begin
            logic [DW:0] t;
            logic [DW:0] d;
            logic qb;
            t = {w_in[k][PW-1:DW], w_in[k][DW-1]};
            d = t - {1'b0, seg_in.e[k].uc};
            qb = (t >= {1'b0, seg_in.e[k].uc});
            w_next[k] = {(qb ? d[DW-1:0] : t[DW-1:0]), w_in[k][DW-2:0], qb};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg <= seg_in;
            w_reg <= w_next;
        end
    end

endmodule

### rtl/lsrc_back.sv
// last stage: crossing points, hit selection and result register
module lsrc_back
    import lsrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  seg_t                 seg_in,
    input  div_w_t               w_in,
    input  logic signed [CW-1:0] clip_left,
    input  logic signed [CW-1:0] clip_bottom,
    input  logic signed [CW-1:0] clip_right,
    input  logic signed [CW-1:0] clip_top,
    output logic                 valid_reg,
    output logic                 vis_reg,
    output logic signed [CW-1:0] sx_reg,
    output logic signed [CW-1:0] sy_reg,
    output logic signed [CW-1:0] ex_reg,
    output logic signed [CW-1:0] ey_reg
);

    edge_hit_t [NEDGE-1:0] h;
    logic signed [NEDGE-1:0][CW-1:0] hx;
    logic signed [NEDGE-1:0][CW-1:0] hy;
    logic vis_next;
    logic signed [CW-1:0] sx_next, sy_next, ex_next, ey_next;
    logic signed [CW-1:0] fx, fy, gx, gy;
    logic [2:0] n;

    always_comb
    begin
        h[E_BOT]   = edge_hit(seg_in.e[E_BOT], w_in[E_BOT][DW-1:0], clip_left, clip_right);
        h[E_TOP]   = edge_hit(seg_in.e[E_TOP], w_in[E_TOP][DW-1:0], clip_left, clip_right);
        h[E_LEFT]  = edge_hit(seg_in.e[E_LEFT], w_in[E_LEFT][DW-1:0], clip_bottom, clip_top);
        h[E_RIGHT] = edge_hit(seg_in.e[E_RIGHT], w_in[E_RIGHT][DW-1:0], clip_bottom,
                              clip_top);
        hx[E_BOT]   = h[E_BOT].ca;
        hy[E_BOT]   = clip_bottom;
        hx[E_TOP]   = h[E_TOP].ca;
        hy[E_TOP]   = clip_top;
        hx[E_LEFT]  = clip_left;
        hy[E_LEFT]  = h[E_LEFT].ca;
        hx[E_RIGHT] = clip_right;
        hy[E_RIGHT] = h[E_RIGHT].ca;

        n = '0;
        fx = '0;
        fy = '0;
        gx = '0;
        gy = '0;
        for (int k = 0; k < NEDGE; k++)
        begin
            if (h[k].hit)
            begin
                if (n == 3'd0)
                begin
                    fx = hx[k];
                    fy = hy[k];
                end
                else if (n == 3'd1)
                begin
                    gx = hx[k];
                    gy = hy[k];
                end
                n = n + 3'd1;
            end
        end

        vis_next = 1'b1;
        sx_next = '0;
        sy_next = '0;
        ex_next = '0;
        ey_next = '0;
        if (seg_in.reject)
        begin
            vis_next = 1'b0;
        end
        else if (seg_in.in0 && seg_in.in1)
        begin
            sx_next = seg_in.x0;
            sy_next = seg_in.y0;
            ex_next = seg_in.x1;
            ey_next = seg_in.y1;
        end
        else if (n == 3'd0)
        begin
            vis_next = 1'b0;
        end
        else if (n == 3'd1)
        begin
            if (seg_in.in0)
            begin
                sx_next = seg_in.x0;
                sy_next = seg_in.y0;
                ex_next = fx;
                ey_next = fy;
            end
            else
            begin
                sx_next = fx;
                sy_next = fy;
                ex_next = seg_in.x1;
                ey_next = seg_in.y1;
            end
        end
        else
        begin
            sx_next = fx;
            sy_next = fy;
            ex_next = gx;
            ey_next = gy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_reg <= vis_next;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            ex_reg <= ex_next;
            ey_reg <= ey_next;
        end
    end

endmodule

### tb/sv/tb_line_segment_rect_clipper_top.sv
// testbench for the line segment rectangle clipper: random and directed segments, scoreboard
`timescale 1ns / 1ps

module tb_line_segment_rect_clipper_top;
    import lsrc_pkg::*;

    typedef struct packed
    {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } segment_t;

    typedef struct packed
    {
        logic                 vis;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } clipped_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CW-1:0] cfg_wdata;

    lsrc_seg_if seg_bus ();
    lsrc_res_if res_bus ();

    line_segment_rect_clipper_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .seg_in    (seg_bus.sink),
        .res_out   (res_bus.source)
    );

    longint rect_left, rect_bottom, rect_right, rect_top;
    segment_t pending_segs[$];
    clipped_t expected_clips[$];
    int send_idle_pct, recv_idle_pct;
    bit hold_recv;
    int errors, accepted, results, visible_count;
    longint cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd2000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch result %0d %s: got %0d expected %0d", results, what, got, want);
    endtask

    // exact a0 + trunc((a1-a0)*(edge_v-b0)/(b1-b0)) with wide signed arithmetic
    function automatic longint cross_coord(input longint a0, input longint b0,
                                           input longint a1, input longint b1,
                                           input longint lo, input longint hi,
                                           input longint edge_v, output bit hit);
        logic signed [127:0] num;
        logic signed [127:0] q;
        longint ca;
        if (b0 == b1)
        begin
            hit = (b1 == edge_v);
            return a0;
        end
        if (edge_v < ((b0 < b1) ? b0 : b1) || edge_v > ((b0 < b1) ? b1 : b0))
        begin
            hit = 1'b0;
            return 0;
        end
        num = 128'(a1 - a0) * 128'(edge_v - b0);
        q = num / 128'(b1 - b0);
        ca = a0 + longint'(q);
        hit = (ca >= lo) && (ca <= hi);
        return ca;
    endfunction

    function automatic clipped_t clip_segment(input segment_t s);
        clipped_t r;
        longint x0, y0, x1, y1, ca;
        longint hx[4], hy[4];
        int n;
        bit hit, in0, in1;
        x0 = s.sx;
        y0 = s.sy;
        x1 = s.ex;
        y1 = s.ey;
        r = '0;
        n = 0;
        if ((x0 < rect_left && x1 < rect_left) || (y0 < rect_bottom && y1 < rect_bottom) ||
            (x0 > rect_right && x1 > rect_right) || (y0 > rect_top && y1 > rect_top))
            return r;
        in0 = x0 >= rect_left && x0 <= rect_right && y0 >= rect_bottom && y0 <= rect_top;
        in1 = x1 >= rect_left && x1 <= rect_right && y1 >= rect_bottom && y1 <= rect_top;
        r.vis = 1'b1;
        if (in0 && in1)
        begin
            r.sx = x0;
            r.sy = y0;
            r.ex = x1;
            r.ey = y1;
            return r;
        end
        ca = cross_coord(x0, y0, x1, y1, rect_left, rect_right, rect_bottom, hit);
        if (hit) begin hx[n] = ca; hy[n] = rect_bottom; n++; end
        ca = cross_coord(x0, y0, x1, y1, rect_left, rect_right, rect_top, hit);
        if (hit) begin hx[n] = ca; hy[n] = rect_top; n++; end
        ca = cross_coord(y0, x0, y1, x1, rect_bottom, rect_top, rect_left, hit);
        if (hit) begin hy[n] = ca; hx[n] = rect_left; n++; end
        ca = cross_coord(y0, x0, y1, x1, rect_bottom, rect_top, rect_right, hit);
        if (hit) begin hy[n] = ca; hx[n] = rect_right; n++; end
        if (n == 0)
            r.vis = 1'b0;
        else if (n == 1)
        begin
            if (in0)
            begin
                r.sx = x0; r.sy = y0; r.ex = hx[0]; r.ey = hy[0];
            end
            else
            begin
                r.sx = hx[0]; r.sy = hy[0]; r.ex = x1; r.ey = y1;
            end
        end
        else
        begin
            r.sx = hx[0]; r.sy = hy[0]; r.ex = hx[1]; r.ey = hy[1];
        end
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_bus.valid <= 1'b0;
            seg_bus.start_x <= '0;
            seg_bus.start_y <= '0;
            seg_bus.end_x <= '0;
            seg_bus.end_y <= '0;
        end
        else
        begin
            automatic bit busy = seg_bus.valid && !seg_bus.ready;
            if (seg_bus.valid && seg_bus.ready)
            begin
                expected_clips.push_back(clip_segment({seg_bus.start_x, seg_bus.start_y,
                                                       seg_bus.end_x, seg_bus.end_y}));
                accepted++;
            end
            if (!busy)
            begin
                if (pending_segs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    automatic segment_t s = pending_segs.pop_front();
                    seg_bus.valid <= 1'b1;
                    seg_bus.start_x <= s.sx;
                    seg_bus.start_y <= s.sy;
                    seg_bus.end_x <= s.ex;
                    seg_bus.end_y <= s.ey;
                end
                else
                    seg_bus.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (expected_clips.size() == 0)
                begin
                    errors++;
                    $display("unexpected result transfer");
                end
                else
                begin
                    automatic clipped_t w = expected_clips.pop_front();
                    if (res_bus.visible !== w.vis)
                        report("visible", res_bus.visible, w.vis);
                    if (res_bus.out_start_x !== w.sx)
                        report("out_start_x", res_bus.out_start_x, w.sx);
                    if (res_bus.out_start_y !== w.sy)
                        report("out_start_y", res_bus.out_start_y, w.sy);
                    if (res_bus.out_end_x !== w.ex)
                        report("out_end_x", res_bus.out_end_x, w.ex);
                    if (res_bus.out_end_y !== w.ey)
                        report("out_end_y", res_bus.out_end_y, w.ey);
                    visible_count += w.vis;
                end
                results++;
            end
            res_bus.ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input longint v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CW'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LEFT:   rect_left = longint'($signed(CW'(v)));
            CFG_BOTTOM: rect_bottom = longint'($signed(CW'(v)));
            CFG_RIGHT:  rect_right = longint'($signed(CW'(v)));
            default:    rect_top = longint'($signed(CW'(v)));
        endcase
    endtask

    task automatic set_rect(input longint l, input longint b, input longint r, input longint t);
        write_reg(CFG_LEFT, l);
        write_reg(CFG_BOTTOM, b);
        write_reg(CFG_RIGHT, r);
        write_reg(CFG_TOP, t);
    endtask

    task automatic drain();
        while (pending_segs.size() > 0 || seg_bus.valid || expected_clips.size() > 0)
            @(posedge clk);
        repeat (CW + 10) @(posedge clk);
    endtask

    function automatic longint rand_coord(input int mode);
        case (mode)
            0: return longint'($signed($urandom()));
            1: return longint'($urandom_range(1200)) - 600;
            default: return longint'($urandom_range(10)) - 5 + (($urandom_range(1)) ? 200 : -200);
        endcase
    endfunction

    task automatic add_seg(input longint a, input longint b, input longint c, input longint d);
        segment_t s;
        s.sx = CW'(a);
        s.sy = CW'(b);
        s.ex = CW'(c);
        s.ey = CW'(d);
        pending_segs.push_back(s);
    endtask

    task automatic random_batch(input int n, input bit wide_rect);
        int mode;
        for (int i = 0; i < n; i++)
        begin
            mode = wide_rect ? 0 : (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 2));
            case ($urandom_range(9))
                0: begin
                    automatic longint y = ($urandom_range(1)) ? rect_bottom : rect_top;
                    add_seg(rand_coord(mode), y, rand_coord(mode), y);
                end
                1: begin
                    automatic longint x = ($urandom_range(1)) ? rect_left : rect_right;
                    add_seg(x, rand_coord(mode), x, rand_coord(mode));
                end
                default: add_seg(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                                 rand_coord(mode));
            endcase
        end
    endtask

    localparam longint MAXC = 64'sd2147483647;
    localparam longint MINC = -64'sd2147483648;

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LEFT;
        cfg_wdata = '0;
        seg_bus.valid = 1'b0;
        seg_bus.start_x = '0;
        seg_bus.start_y = '0;
        seg_bus.end_x = '0;
        seg_bus.end_y = '0;
        res_bus.ready = 1'b0;
        rect_left = 0; rect_bottom = 0; rect_right = 0; rect_top = 0;
        errors = 0; accepted = 0; results = 0; visible_count = 0; cycles = 0;
        send_idle_pct = 0; recv_idle_pct = 0; hold_recv = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset rectangle is a point at the origin
        add_seg(-256, 0, 256, 0);
        add_seg(0, 0, 0, 0);
        drain();

        set_rect(-200, -200, 200, 200);
        add_seg(-100, -100, 100, 100);
        add_seg(-300, -300, -250, 100);
        add_seg(300, 0, 400, 10);
        add_seg(0, -300, 10, -250);
        add_seg(0, 300, 10, 400);
        add_seg(0, 0, 0, 500);
        add_seg(0, 500, 0, 0);
        add_seg(-500, 0, 500, 0);
        add_seg(-500, -500, 500, 500);
        add_seg(-500, 100, 100, 500);
        add_seg(-300, 200, 300, 200);
        add_seg(-200, -300, -200, 300);
        add_seg(-300, -210, 300, -201);
        add_seg(MINC, MINC, MAXC, MAXC);
        add_seg(MAXC, MINC, MINC, MAXC);
        add_seg(MINC, 0, MAXC, 1);
        add_seg(-7, -333, 3, 999);
        drain();

        set_rect(MINC, MINC, MAXC, MAXC);
        add_seg(MINC, MAXC, MAXC, MINC);
        add_seg(0, 0, -1, -1);
        random_batch(30, 1'b1);
        drain();

        // inverted rectangle
        set_rect(100, 100, -100, -100);
        random_batch(40, 1'b0);
        drain();

        set_rect(-200, -200, 200, 200);
        send_idle_pct = 19; recv_idle_pct = 66;
        random_batch(600, 1'b0);
        drain();

        set_rect(-150, -190, 210, 170);
        send_idle_pct = 66; recv_idle_pct = 19;
        random_batch(600, 1'b0);
        drain();

        set_rect(-256, -100, 180, 240);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_batch(600, 1'b0);
        hold_recv = 1'b1;
        repeat (200) @(posedge clk);
        hold_recv = 1'b0;
        drain();

        $display("segments sent %0d, results checked %0d, visible %0d", accepted, results,
                 visible_count);
        $display("rectangles: reset point, symmetric, full range, inverted, offset; stalls");
        if (errors == 0 && expected_clips.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### line_segment_rect_clipper_top.f
rtl/lsrc_pkg.sv
rtl/lsrc_if.sv
rtl/lsrc_front.sv
rtl/lsrc_mul.sv
rtl/lsrc_div_step.sv
rtl/lsrc_back.sv
rtl/line_segment_rect_clipper_top.sv
tb/sv/tb_line_segment_rect_clipper_top.sv
